>>> rtl/wheel_position_pid_with_deadband_defines.svh
// assertion macros for the wheel position pid block
// used by the top level only, expects clk and rst_n in scope
`ifndef WHEEL_POSITION_PID_WITH_DEADBAND_DEFINES_SVH
`define WHEEL_POSITION_PID_WITH_DEADBAND_DEFINES_SVH

// same-cycle implication
`define WPPID_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WPPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wppid_pkg.sv
// shared types and constants for the wheel position pid block
// no dependencies
package wppid_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  localparam int CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET    = 3'd0,
    REG_GAIN_P    = 3'd1,
    REG_GAIN_I    = 3'd2,
    REG_GAIN_D    = 3'd3,
    REG_INT_LIMIT = 3'd4,
    REG_DEADBAND  = 3'd5
  } cfg_reg_t;

  localparam logic [15:0] DUTY_STOP      = 16'd25600;
  localparam logic [15:0] DUTY_FULL      = 16'd51200;
  localparam int          FULL_PERCENT   = 100;
  localparam logic [15:0] DEADBAND_RESET = 16'd10;
  localparam int          QUEUE_DEPTH    = 4;

  typedef struct packed {
    logic signed [31:0] target;
    logic [30:0]        int_limit;
    logic [15:0]        deadband;
  } loop_cfg_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } gain_cfg_t;

  typedef struct packed {
    logic               pid;
    logic               arrive;
    logic               mode;
    logic signed [31:0] err;
    logic signed [31:0] err_sum;
    logic signed [32:0] err_delta;
  } work_t;

  typedef struct packed {
    logic               duty_valid;
    logic [15:0]        duty;
    logic               mode;
    logic signed [31:0] err;
  } result_t;

endpackage

>>> rtl/wppid_fifo.sv
// small first-in first-out queue of packed words
// no dependencies
module wppid_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/wppid_front.sv
// front end: position count, error, mode and error sum recurrences
// depends on wppid_pkg
module wppid_front
  import wppid_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  loop_cfg_t                     cfg,
  input  logic                          push,
  output logic                          full,
  input  op_t                           operation,
  input  logic signed [COUNT_WIDTH-1:0] count_delta,
  output logic                          wr_en,
  output work_t                         wr_data,
  input  logic                          q_full
);

  logic               en;
  logic               accept;
  logic signed [31:0] delta32;

  logic signed [31:0] pos_r, pos_nxt;

  logic               s1_v_r;
  op_t                s1_op_r;
  logic signed [31:0] s1_pos_r;

  logic               s2_v_r;
  op_t                s2_op_r;
  logic signed [31:0] s2_err_r;

  logic               s3_v_r;
  work_t              s3_r, s3_nxt;

  logic               mode_r, mode_nxt;
  logic signed [31:0] sum_r, sum_nxt;
  logic signed [31:0] prev_r, prev_nxt;

  logic signed [32:0] diff;
  logic signed [31:0] err;
  logic signed [32:0] sum_raw;
  logic signed [32:0] lim;
  logic signed [32:0] sum_clamped;
  logic [31:0]        mag;
  logic               arrive;

  assign en      = !s3_v_r || !q_full;
  assign full    = !en;
  assign accept  = push && en;
  assign delta32 = 32'(count_delta);
  assign wr_en   = s3_v_r && en;
  assign wr_data = s3_r;

  always_comb begin
    pos_nxt = pos_r;
    if (accept && operation == OP_TICK) begin
      pos_nxt = pos_r + delta32;
    end
  end

  // saturated position minus target
  always_comb begin
    diff = 33'(s1_pos_r) - 33'(cfg.target);
    if (diff[32] != diff[31]) begin
      err = diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      err = diff[31:0];
    end
  end

  always_comb begin
    sum_raw = 33'(sum_r) + 33'(s2_err_r);
    lim     = signed'({2'b00, cfg.int_limit});
    if (sum_raw > lim) begin
      sum_clamped = lim;
    end else if (sum_raw < -lim) begin
      sum_clamped = -lim;
    end else begin
      sum_clamped = sum_raw;
    end
    mag    = s2_err_r[31] ? (~s2_err_r + 32'd1) : s2_err_r;
    arrive = (mag <= {16'd0, cfg.deadband});

    mode_nxt = mode_r;
    sum_nxt  = sum_r;
    prev_nxt = prev_r;

    s3_nxt.pid       = 1'b0;
    s3_nxt.arrive    = arrive;
    s3_nxt.err       = s2_err_r;
    s3_nxt.err_sum   = sum_clamped[31:0];
    s3_nxt.err_delta = 33'(s2_err_r) - 33'(prev_r);

    if (s2_v_r) begin
      if (s2_op_r == OP_START) begin
        mode_nxt = 1'b1;
      end else if (mode_r) begin
        s3_nxt.pid = 1'b1;
        sum_nxt    = sum_clamped[31:0];
        prev_nxt   = s2_err_r;
        mode_nxt   = !arrive;
      end
    end
    s3_nxt.mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= 1'b0;
      sum_r  <= '0;
      prev_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      sum_r  <= sum_nxt;
      prev_r <= prev_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op_r  <= operation;
      s1_pos_r <= pos_nxt;
      s2_op_r  <= s1_op_r;
      s2_err_r <= err;
      s3_r     <= s3_nxt;
    end
  end

endmodule

>>> rtl/wppid_back.sv
// back end: gain products, drive sum, clamp and duty scaling
// depends on wppid_pkg
module wppid_back
  import wppid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  gain_cfg_t gains,
  output logic      rd_en,
  input  work_t     rd_data,
  input  logic      q_empty,
  output logic      wr_en,
  output result_t   wr_data,
  input  logic      q_full
);

  localparam int                 DPW    = GAIN_FRAC_BITS + 9;
  localparam logic signed [51:0] FULL_Q = 52'(FULL_PERCENT) <<< GAIN_FRAC_BITS;

  logic               en;

  logic signed [16:0] gp_s, gi_s, gd_s;
  logic signed [48:0] prod_p, prod_i;
  logic signed [49:0] prod_d;

  logic               b1_v_r;
  logic signed [48:0] b1_p_r, b1_i_r;
  logic signed [49:0] b1_d_r;
  logic               b1_pid_r, b1_arrive_r, b1_mode_r;
  logic signed [31:0] b1_err_r;

  logic               b2_v_r;
  logic signed [51:0] b2_drive_r;
  logic               b2_pid_r, b2_arrive_r, b2_mode_r;
  logic signed [31:0] b2_err_r;

  logic signed [51:0] drive_c;
  logic signed [51:0] shifted_up;
  logic [DPW-1:0]     dp;
  logic [DPW+7:0]     scaled;

  assign en    = !b2_v_r || !q_full;
  assign rd_en = en && !q_empty;
  assign wr_en = b2_v_r && en;

  assign gp_s   = signed'({1'b0, gains.gain_p});
  assign gi_s   = signed'({1'b0, gains.gain_i});
  assign gd_s   = signed'({1'b0, gains.gain_d});
  assign prod_p = gp_s * rd_data.err;
  assign prod_i = gi_s * rd_data.err_sum;
  assign prod_d = gd_s * rd_data.err_delta;

  always_comb begin
    if (b2_drive_r > FULL_Q) begin
      drive_c = FULL_Q;
    end else if (b2_drive_r < -FULL_Q) begin
      drive_c = -FULL_Q;
    end else begin
      drive_c = b2_drive_r;
    end
    shifted_up = drive_c + FULL_Q;
    dp         = shifted_up[DPW-1:0];
    scaled     = {dp, 8'd0} >> GAIN_FRAC_BITS;

    wr_data.duty_valid = b2_pid_r;
    wr_data.mode       = b2_mode_r;
    wr_data.err        = b2_err_r;
    if (b2_pid_r && !b2_arrive_r) begin
      wr_data.duty = scaled[15:0];
    end else begin
      wr_data.duty = DUTY_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= !q_empty;
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_p_r      <= prod_p;
      b1_i_r      <= prod_i;
      b1_d_r      <= prod_d;
      b1_pid_r    <= rd_data.pid;
      b1_arrive_r <= rd_data.arrive;
      b1_mode_r   <= rd_data.mode;
      b1_err_r    <= rd_data.err;
      b2_drive_r  <= 52'(b1_p_r) + 52'(b1_i_r) + 52'(b1_d_r);
      b2_pid_r    <= b1_pid_r;
      b2_arrive_r <= b1_arrive_r;
      b2_mode_r   <= b1_mode_r;
      b2_err_r    <= b1_err_r;
    end
  end

endmodule

>>> rtl/wheel_position_pid_with_deadband.sv
// top level of the wheel position pid with deadband
// depends on wppid_pkg, wppid_fifo, wppid_front, wppid_back and the defines header
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   input   | push / full        | in_operation, in_count_delta
//   result  | pop / empty        | out_duty_valid, out_duty, out_in_position_mode,
//           |                    | out_position_error
//   config  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one request per cycle sustained while results are popped and full stays low
// front: count, error and state recurrences in three stages; back: two stages after a
// four-entry queue; results wait in a four-entry output queue
// reset clears state and loads register defaults, no clearing pass
// full rises only when the middle queue is full and the front's last stage holds a request
`include "wheel_position_pid_with_deadband_defines.svh"

module wheel_position_pid_with_deadband
  import wppid_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int COUNT_WIDTH    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_operation,
  input  logic signed [COUNT_WIDTH-1:0] in_count_delta,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_duty_valid,
  output logic [15:0]                   out_duty,
  output logic                          out_in_position_mode,
  output logic signed [31:0]            out_position_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int WORK_W   = $bits(work_t);
  localparam int RESULT_W = $bits(result_t);

  logic signed [31:0] target_r;
  logic [15:0]        gain_p_r, gain_i_r, gain_d_r;
  logic [30:0]        int_limit_r;
  logic [15:0]        deadband_r;

  loop_cfg_t loop_cfg;
  gain_cfg_t gains;

  logic    mq_wr, mq_rd, mq_full, mq_empty;
  work_t   mq_wr_data, mq_rd_data;
  logic    oq_wr, oq_full;
  result_t oq_wr_data, oq_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      int_limit_r <= '0;
      deadband_r  <= DEADBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET:    target_r    <= cfg_data;
        REG_GAIN_P:    gain_p_r    <= cfg_data[15:0];
        REG_GAIN_I:    gain_i_r    <= cfg_data[15:0];
        REG_GAIN_D:    gain_d_r    <= cfg_data[15:0];
        REG_INT_LIMIT: int_limit_r <= cfg_data[30:0];
        REG_DEADBAND:  deadband_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign loop_cfg.target    = target_r;
  assign loop_cfg.int_limit = int_limit_r;
  assign loop_cfg.deadband  = deadband_r;
  assign gains.gain_p       = gain_p_r;
  assign gains.gain_i       = gain_i_r;
  assign gains.gain_d       = gain_d_r;

  wppid_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (loop_cfg),
    .push        (push),
    .full        (full),
    .operation   (op_t'(in_operation)),
    .count_delta (in_count_delta),
    .wr_en       (mq_wr),
    .wr_data     (mq_wr_data),
    .q_full      (mq_full)
  );

  wppid_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mq_wr),
    .wr_data (mq_wr_data),
    .rd_en   (mq_rd),
    .rd_data (mq_rd_data),
    .full    (mq_full),
    .empty   (mq_empty)
  );

  wppid_back #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .gains   (gains),
    .rd_en   (mq_rd),
    .rd_data (mq_rd_data),
    .q_empty (mq_empty),
    .wr_en   (oq_wr),
    .wr_data (oq_wr_data),
    .q_full  (oq_full)
  );

  wppid_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_wr),
    .wr_data (oq_wr_data),
    .rd_en   (pop),
    .rd_data (oq_rd_data),
    .full    (oq_full),
    .empty   (empty)
  );

  assign out_duty_valid       = oq_rd_data.duty_valid;
  assign out_duty             = oq_rd_data.duty;
  assign out_in_position_mode = oq_rd_data.mode;
  assign out_position_error   = oq_rd_data.err;

  `WPPID_ASSERT_NOW(a_duty_range, !empty, out_duty <= DUTY_FULL, "duty above full scale")
  `WPPID_ASSERT_NOW(a_idle_duty, !empty && !out_duty_valid, out_duty == DUTY_STOP, "undriven duty not stop")
  `WPPID_ASSERT_NOW(a_drive_mode, !empty && out_duty_valid && out_duty != DUTY_STOP, out_in_position_mode, "driven duty outside position mode")
  `WPPID_ASSERT_NEXT(a_stall_holds, full && !mq_rd, full, "front stall released without drain")

endmodule
